/* design/eatbv_pkg.sv */
// package: constants, types and helpers for the euler angle to basis vector block
`timescale 1ns / 1ps
package eatbv_pkg;
	localparam int AngW = 16;
	localparam int OutW = 16;
	localparam int ZW = 34;
	localparam int XW = 34;
	localparam int AtanCount = 24;
	localparam logic [14:0] TurnUnits = 15'd23040;
	localparam logic [12:0] QuarterUnits = 13'd5760;
	localparam logic [18:0] RadPerUnit = 19'd292818;
	localparam logic signed [XW-1:0] CordicStart = 34'sd652032874;
	localparam logic signed [16:0] OneQ14 = 17'sd16384;

	typedef logic signed [15:0] q14_t;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
	} cordic_t;

	typedef struct packed {
		q14_t sn;
		q14_t cs;
	} sc_t;

	function automatic logic signed [ZW-1:0] atan_q30(input int i);
		logic signed [ZW-1:0] r;
		case (i)
			0: r = 34'sd843314856;
			1: r = 34'sd497837829;
			2: r = 34'sd263043836;
			3: r = 34'sd133525158;
			4: r = 34'sd67021686;
			5: r = 34'sd33543515;
			6: r = 34'sd16775850;
			7: r = 34'sd8388437;
			8: r = 34'sd4194282;
			9: r = 34'sd2097149;
			10: r = 34'sd1048575;
			11: r = 34'sd524287;
			12: r = 34'sd262143;
			13: r = 34'sd131071;
			14: r = 34'sd65535;
			15: r = 34'sd32767;
			16: r = 34'sd16383;
			17: r = 34'sd8191;
			18: r = 34'sd4095;
			19: r = 34'sd2047;
			20: r = 34'sd1023;
			21: r = 34'sd511;
			22: r = 34'sd255;
			23: r = 34'sd127;
			default: r = '0;
		endcase
		return r;
	endfunction

	// round a Q2.30 value half up to Q2.14 and clamp to plus or minus one
	function automatic q14_t round_q14(input logic signed [XW-1:0] v);
		logic signed [XW-1:0] s;
		logic signed [XW-17:0] r;
		s = v + 34'sd32768;
		r = s[XW-1:16];
		if (r > 18'sd16384) return 16'sd16384;
		if (r < -18'sd16384) return -16'sd16384;
		return r[15:0];
	endfunction

	// round a Q2.42 sum half up to Q2.14 and saturate
	function automatic q14_t out42(input logic signed [47:0] v);
		logic signed [47:0] s;
		logic signed [19:0] r;
		s = v + 48'sd134217728;
		r = s[47:28];
		if (r > 20'sd16384) return 16'sd16384;
		if (r < -20'sd16384) return -16'sd16384;
		return r[15:0];
	endfunction
endpackage

/* design/eatbv_if.sv */
// valid/ready channel interfaces for angle items and basis vector items
`timescale 1ns / 1ps
interface eatbv_in_if;
	logic valid;
	logic ready;
	logic signed [15:0] pitch_deg;
	logic signed [15:0] yaw_deg;
	logic signed [15:0] roll_deg;
	modport source (output valid, pitch_deg, yaw_deg, roll_deg, input ready);
	modport sink (input valid, pitch_deg, yaw_deg, roll_deg, output ready);
endinterface

interface eatbv_out_if;
	logic valid;
	logic ready;
	logic signed [15:0] forward_x;
	logic signed [15:0] forward_y;
	logic signed [15:0] forward_z;
	logic signed [15:0] right_x;
	logic signed [15:0] right_y;
	logic signed [15:0] right_z;
	logic signed [15:0] up_x;
	logic signed [15:0] up_y;
	logic signed [15:0] up_z;
	modport source (output valid, forward_x, forward_y, forward_z, right_x, right_y,
		right_z, up_x, up_y, up_z, input ready);
	modport sink (input valid, forward_x, forward_y, forward_z, right_x, right_y,
		right_z, up_x, up_y, up_z, output ready);
endinterface

/* design/eatbv_cordic.sv */
// pipelined sine/cosine unit for three angles, one cordic iteration per stage
`timescale 1ns / 1ps
module eatbv_cordic #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic signed [15:0] ang [3],
	output logic out_valid,
	output eatbv_pkg::sc_t sc [3]
);
	import eatbv_pkg::*;
	localparam int Iters = (CORDIC_STEPS < AtanCount) ? CORDIC_STEPS : AtanCount;
	localparam int NS = Iters + 3;

	logic vld_q [NS];
	logic [14:0] r_s1 [3];
	logic [1:0] qd_q [Iters+1][3];
	cordic_t c_q [Iters+1][3];
	sc_t sc_q [3];

	// stage 1: reduce modulo one turn
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				logic signed [16:0] a;
				a = {ang[k][15], ang[k]};
				if (a < 0) a = a + 17'sd23040;
				if (a < 0) a = a + 17'sd23040;
				if (a >= 17'sd23040) a = a - 17'sd23040;
				r_s1[k] <= a[14:0];
			end
		end
	end

	// stage 2: quadrant split and angle scaling
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				logic [14:0] t;
				logic [1:0] q;
				t = r_s1[k];
				q = 2'd0;
				if (t >= 15'd17280) begin t = t - 15'd17280; q = 2'd3; end
				else if (t >= 15'd11520) begin t = t - 15'd11520; q = 2'd2; end
				else if (t >= 15'd5760) begin t = t - 15'd5760; q = 2'd1; end
				qd_q[0][k] <= q;
				c_q[0][k].x <= CordicStart;
				c_q[0][k].y <= '0;
				c_q[0][k].z <= $signed(ZW'({1'b0, t[12:0]})) * $signed(ZW'(RadPerUnit));
			end
		end
	end

	for (genvar i = 0; i < Iters; i++) begin : g_it
		always_ff @(posedge clk) begin
			if (en) begin
				for (int k = 0; k < 3; k++) begin
					logic signed [XW-1:0] dx, dy;
					dx = c_q[i][k].y >>> i;
					dy = c_q[i][k].x >>> i;
					qd_q[i+1][k] <= qd_q[i][k];
					if (!c_q[i][k].z[ZW-1]) begin
						c_q[i+1][k].x <= c_q[i][k].x - dx;
						c_q[i+1][k].y <= c_q[i][k].y + dy;
						c_q[i+1][k].z <= c_q[i][k].z - atan_q30(i);
					end else begin
						c_q[i+1][k].x <= c_q[i][k].x + dx;
						c_q[i+1][k].y <= c_q[i][k].y - dy;
						c_q[i+1][k].z <= c_q[i][k].z + atan_q30(i);
					end
				end
			end
		end
	end

	// last stage: round, clamp and quadrant fix
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				q14_t s, c;
				s = round_q14(c_q[Iters][k].y);
				c = round_q14(c_q[Iters][k].x);
				case (qd_q[Iters][k])
					2'd0: begin sc_q[k].sn <= s; sc_q[k].cs <= c; end
					2'd1: begin sc_q[k].sn <= c; sc_q[k].cs <= -s; end
					2'd2: begin sc_q[k].sn <= -s; sc_q[k].cs <= -c; end
					default: begin sc_q[k].sn <= -c; sc_q[k].cs <= s; end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NS; j++) vld_q[j] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= in_valid;
			for (int j = 1; j < NS; j++) vld_q[j] <= vld_q[j-1];
		end
	end

	assign out_valid = vld_q[NS-1];
	assign sc = sc_q;
endmodule

/* design/euler_angles_to_basis_vectors_top.sv */
// top level: euler angles to forward, right and up basis vectors
`timescale 1ns / 1ps
// Takes pitch, yaw and roll in 1/64 degree and returns the forward, right and up
// unit vectors in Q2.14, each component saturated to plus or minus 16384. Fully
// pipelined: one item per cycle while the output is not stalled, through reduction,
// quadrant, min(steps,24) cordic stages, rounding, three product stages and the output
// register. The whole pipe holds while the output item waits and ready is low.
module euler_angles_to_basis_vectors_top #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic clk,
	input  logic arst_n,
	eatbv_in_if.sink  in_ch,
	eatbv_out_if.source out_ch
);
	import eatbv_pkg::*;

	logic en, cv;
	logic signed [15:0] ang [3];
	sc_t sc [3];
	logic v_s1, v_s2, v_s3;
	logic signed [31:0] spcy_s1, spsy_s1, cpcy_s1, cpsy_s1, cpcr_s1, cpsr_s1;
	logic signed [15:0] sp_s1, cr_s1, sr_s1, sy_s1, cy_s1;
	logic signed [31:0] crsy_s2, crcy_s2, srsy_s2, srcy_s2;
	logic signed [47:0] a_s2 [9];
	logic signed [47:0] rx_s3, ry_s3, ux_s3, uy_s3;
	logic signed [47:0] p_s3 [5];
	q14_t o_q [9];
	logic ov_q;

	assign en = !ov_q || out_ch.ready;
	assign in_ch.ready = en;
	assign ang[0] = in_ch.pitch_deg;
	assign ang[1] = in_ch.yaw_deg;
	assign ang[2] = in_ch.roll_deg;

	eatbv_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(in_ch.valid),
		.ang(ang), .out_valid(cv), .sc(sc)
	);

	// product stage 1: pairwise products
	always_ff @(posedge clk) begin
		if (en) begin
			spcy_s1 <= sc[0].sn * sc[1].cs;
			spsy_s1 <= sc[0].sn * sc[1].sn;
			cpcy_s1 <= sc[0].cs * sc[1].cs;
			cpsy_s1 <= sc[0].cs * sc[1].sn;
			cpcr_s1 <= sc[0].cs * sc[2].cs;
			cpsr_s1 <= sc[0].cs * sc[2].sn;
			sp_s1 <= sc[0].sn;
			cr_s1 <= sc[2].cs;
			sr_s1 <= sc[2].sn;
			sy_s1 <= sc[1].sn;
			cy_s1 <= sc[1].cs;
		end
	end

	// product stage 2: triple products in Q2.42, plus the roll-yaw pairwise products
	always_ff @(posedge clk) begin
		if (en) begin
			a_s2[0] <= 48'(cpcy_s1) <<< 14;
			a_s2[1] <= 48'(cpsy_s1) <<< 14;
			a_s2[2] <= -(48'(sp_s1) <<< 28);
			a_s2[3] <= -(48'(sr_s1) * 48'(spcy_s1));
			a_s2[4] <= -(48'(sr_s1) * 48'(spsy_s1));
			a_s2[5] <= -(48'(cpsr_s1) <<< 14);
			a_s2[6] <= 48'(cr_s1) * 48'(spcy_s1);
			a_s2[7] <= 48'(cr_s1) * 48'(spsy_s1);
			a_s2[8] <= 48'(cpcr_s1) <<< 14;
			crsy_s2 <= cr_s1 * sy_s1;
			crcy_s2 <= cr_s1 * cy_s1;
			srsy_s2 <= sr_s1 * sy_s1;
			srcy_s2 <= sr_s1 * cy_s1;
		end
	end

	// stage 3: sums
	always_ff @(posedge clk) begin
		if (en) begin
			rx_s3 <= a_s2[3] + (48'(crsy_s2) <<< 14);
			ry_s3 <= a_s2[4] - (48'(crcy_s2) <<< 14);
			ux_s3 <= a_s2[6] + (48'(srsy_s2) <<< 14);
			uy_s3 <= a_s2[7] - (48'(srcy_s2) <<< 14);
			p_s3[0] <= a_s2[0];
			p_s3[1] <= a_s2[1];
			p_s3[2] <= a_s2[2];
			p_s3[3] <= a_s2[5];
			p_s3[4] <= a_s2[8];
		end
	end

	// output register: round and saturate
	always_ff @(posedge clk) begin
		if (en) begin
			o_q[0] <= out42(p_s3[0]);
			o_q[1] <= out42(p_s3[1]);
			o_q[2] <= out42(p_s3[2]);
			o_q[3] <= out42(rx_s3);
			o_q[4] <= out42(ry_s3);
			o_q[5] <= out42(p_s3[3]);
			o_q[6] <= out42(ux_s3);
			o_q[7] <= out42(uy_s3);
			o_q[8] <= out42(p_s3[4]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			ov_q <= 1'b0;
		end else if (en) begin
			v_s1 <= cv;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			ov_q <= v_s3;
		end
	end

	assign out_ch.valid = ov_q;
	assign out_ch.forward_x = o_q[0];
	assign out_ch.forward_y = o_q[1];
	assign out_ch.forward_z = o_q[2];
	assign out_ch.right_x = o_q[3];
	assign out_ch.right_y = o_q[4];
	assign out_ch.right_z = o_q[5];
	assign out_ch.up_x = o_q[6];
	assign out_ch.up_y = o_q[7];
	assign out_ch.up_z = o_q[8];
endmodule

/* design/eatbv_checker.sv */
// port-level checker for the basis vector block, bound to the top level
`timescale 1ns / 1ps
module eatbv_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic signed [15:0] forward_z,
	input logic signed [15:0] up_z,
	input logic signed [15:0] right_z
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(forward_z) && $stable(up_z))
		else $error("output item changed while stalled");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while pipe stalled");
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input refused with empty output");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> forward_z <= 16'sd16384 && forward_z >= -16'sd16384
			&& right_z <= 16'sd16384 && right_z >= -16'sd16384)
		else $error("output component out of range");
endmodule

bind euler_angles_to_basis_vectors_top eatbv_checker u_eatbv_checker (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.forward_z(out_ch.forward_z), .up_z(out_ch.up_z), .right_z(out_ch.right_z)
);

/* tb/testbench.sv */
// testbench: random and directed angle items checked against a fixed-point basis vector predictor
`timescale 1ns / 1ps
module testbench;
	import eatbv_pkg::*;

	localparam int Steps = 16;
	localparam int Latency = Steps + 7;

	typedef struct packed {
		logic signed [15:0] pitch;
		logic signed [15:0] yaw;
		logic signed [15:0] roll;
	} angles_t;

	typedef struct packed {
		logic signed [15:0] fx, fy, fz, rx, ry, rz, ux, uy, uz;
	} basis_t;

	logic clk;
	logic arst_n;
	eatbv_in_if in_ch();
	eatbv_out_if out_ch();

	euler_angles_to_basis_vectors_top #(.CORDIC_STEPS(Steps)) i_dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	angles_t pending_angles[$];
	basis_t expected_basis[$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_sender = 0;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic longint fshift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint clamp1(longint v);
		if (v > 16384) return 16384;
		if (v < -16384) return -16384;
		return v;
	endfunction

	function automatic longint atan_entry(int i);
		longint tbl[24] = '{843314856, 497837829, 263043836, 133525158, 67021686,
			33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287,
			262143, 131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511,
			255, 127};
		return tbl[i];
	endfunction

	task automatic angle_sin_cos(input logic signed [15:0] a, output longint sn,
			output longint cs);
		longint r, q, t, x, y, z, dx, dy, s14, c14;
		r = longint'(a) % 23040;
		if (r < 0) r += 23040;
		q = r / 5760;
		t = r % 5760;
		x = 652032874;
		y = 0;
		z = t * 292818;
		for (int i = 0; i < Steps && i < 24; i++) begin
			dx = fshift(y, i);
			dy = fshift(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_entry(i);
			end else begin
				x += dx; y -= dy; z += atan_entry(i);
			end
		end
		s14 = clamp1(fshift(y + (64'sd1 << 15), 16));
		c14 = clamp1(fshift(x + (64'sd1 << 15), 16));
		case (q)
			0: begin sn = s14; cs = c14; end
			1: begin sn = c14; cs = -s14; end
			2: begin sn = -s14; cs = -c14; end
			default: begin sn = -c14; cs = s14; end
		endcase
	endtask

	function automatic logic signed [15:0] round42(longint v);
		longint r;
		r = clamp1(fshift(v + (64'sd1 << 27), 28));
		return r[15:0];
	endfunction

	task automatic predict_basis(input angles_t a, output basis_t b);
		longint sp, cp, sy, cy, sr, cr, k;
		k = 16384;
		angle_sin_cos(a.pitch, sp, cp);
		angle_sin_cos(a.yaw, sy, cy);
		angle_sin_cos(a.roll, sr, cr);
		b.fx = round42(cp * cy * k);
		b.fy = round42(cp * sy * k);
		b.fz = round42(-sp * k * k);
		b.rx = round42(-sr * sp * cy + cr * sy * k);
		b.ry = round42(-sr * sp * sy - cr * cy * k);
		b.rz = round42(-sr * cp * k);
		b.ux = round42(cr * sp * cy + sr * sy * k);
		b.uy = round42(cr * sp * sy - sr * cy * k);
		b.uz = round42(cr * cp * k);
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.pitch_deg <= '0;
			in_ch.yaw_deg <= '0;
			in_ch.roll_deg <= '0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (pending_angles.size() > 0 && !hold_sender &&
					$urandom_range(99) >= send_idle_pct) begin
				angles_t a;
				basis_t b;
				a = pending_angles.pop_front();
				predict_basis(a, b);
				expected_basis.push_back(b);
				in_ch.valid <= 1'b1;
				in_ch.pitch_deg <= a.pitch;
				in_ch.yaw_deg <= a.yaw;
				in_ch.roll_deg <= a.roll;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_basis.size() == 0) begin
					report_mismatch("unexpected item", 0, 0);
				end else begin
					basis_t w;
					w = expected_basis.pop_front();
					if (out_ch.forward_x !== w.fx) report_mismatch("forward_x", out_ch.forward_x, w.fx);
					if (out_ch.forward_y !== w.fy) report_mismatch("forward_y", out_ch.forward_y, w.fy);
					if (out_ch.forward_z !== w.fz) report_mismatch("forward_z", out_ch.forward_z, w.fz);
					if (out_ch.right_x !== w.rx) report_mismatch("right_x", out_ch.right_x, w.rx);
					if (out_ch.right_y !== w.ry) report_mismatch("right_y", out_ch.right_y, w.ry);
					if (out_ch.right_z !== w.rz) report_mismatch("right_z", out_ch.right_z, w.rz);
					if (out_ch.up_x !== w.ux) report_mismatch("up_x", out_ch.up_x, w.ux);
					if (out_ch.up_y !== w.uy) report_mismatch("up_y", out_ch.up_y, w.uy);
					if (out_ch.up_z !== w.uz) report_mismatch("up_z", out_ch.up_z, w.uz);
				end
			end
			out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic logic signed [15:0] rand_angle();
		case ($urandom_range(3))
			0: return 16'($urandom_range(23039));
			1: return -$signed(16'($urandom_range(23040)));
			2: return 16'($urandom_range(3) * 5760 + $urandom_range(2) - 1);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic push_angles(input logic signed [15:0] p, y, r);
		angles_t a;
		a.pitch = p; a.yaw = y; a.roll = r;
		pending_angles.push_back(a);
	endtask

	task automatic wait_drained();
		while (pending_angles.size() > 0 || expected_basis.size() > 0 || in_ch.valid)
			@(posedge clk);
	endtask

	initial begin
		logic signed [15:0] corner[10];
		corner = '{16'sd0, 16'sd5760, 16'sd11520, 16'sd17280,
			16'sd23040, -16'sd5760, 16'sd32767, -16'sd32768, 16'sd5759, 16'sd1};
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		for (int i = 0; i < 10; i++)
			push_angles(corner[i], corner[(i + 3) % 10], corner[(i + 7) % 10]);
		for (int i = 0; i < 10; i++)
			push_angles(corner[(i + 5) % 10], corner[i], corner[(i + 1) % 10]);
		push_angles(16'sh5555, 16'shAAAA, 16'sh7FFF);
		push_angles(16'shAAAA, 16'sh5555, -16'sd1);
		for (int ph = 0; ph < 4; ph++) begin
			wait_drained();
			send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 52 : 21) : 0;
			recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 52 : 21) : 0;
			for (int n = 0; n < 245; n++)
				push_angles(rand_angle(), rand_angle(), rand_angle());
			if (ph == 1) begin
				while (pending_angles.size() > 120) @(posedge clk);
				hold_sender = 1'b1;
				while (expected_basis.size() > 0 || in_ch.valid) @(posedge clk);
				hold_sender = 1'b0;
			end
		end
		wait_drained();
		repeat (Latency + 10) @(posedge clk);
		if (errors == 0) $display("[euler_angles_to_basis_vectors_top] OK");
		else $display("[euler_angles_to_basis_vectors_top] ERROR");
		$finish;
	end

	initial begin
		#2ms;
		$display("[euler_angles_to_basis_vectors_top] ERROR");
		$finish;
	end
endmodule
